FILE: hdl/bac_pkg.sv
package bac_pkg;

   localparam int WORD_BITS = 32;
   localparam int PRED_W    = 16;
   localparam int CNT_W     = 6;
   localparam int PROD_W    = WORD_BITS + PRED_W;

   // Item kinds carried on the request tuser
   typedef enum logic [1:0] {
      MODE_ENCODE  = 2'd0,
      MODE_FLUSH   = 2'd1,
      MODE_DECODE  = 2'd2,
      MODE_CODE_IN = 2'd3
   } mode_type;

   // Source of the response beat
   typedef enum logic [1:0] {
      EMIT_CODE,
      EMIT_DECODE,
      EMIT_PRELOAD
   } emit_kind_type;

   typedef struct packed {
      logic          latch;         // take a new item, clear the shift count
      logic          code_in;       // shift the request bit into the code window
      logic          mul;           // register span times prediction
      logic          split;         // clamp split point and narrow the interval
      logic          split_decode;  // pick the bit from the code window
      logic          shift;         // shift both bounds one place
      logic          emit;          // load the response register
      emit_kind_type emit_kind;
      logic          emit_last;
   } cmd_type;

   typedef struct packed {
      logic agree;         // top bits of low and high match
      logic agree_next;    // they still match after one more shift
      logic count_last;    // shift count is at its final bit
      logic count_full;    // shift count reached the word width
      logic preload_zero;  // code window fully preloaded
      logic out_free;      // response register can take a beat
   } status_type;

endpackage

FILE: hdl/bac_datapath.sv
module bac_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_bit,
   input  logic [bac_pkg::PRED_W-1:0]         req_pred,
   input  bac_pkg::cmd_type                   cmd,
   output bac_pkg::status_type                status,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic                               rsp_out_bit,
   output logic [bac_pkg::CNT_W-1:0]          rsp_count,
   output logic                               rsp_last
);

   localparam int W = bac_pkg::WORD_BITS;

   logic [W-1:0]                    low_ff, low_in;
   logic [W-1:0]                    high_ff, high_in;
   logic [W-1:0]                    window_ff, window_in;
   logic [bac_pkg::CNT_W-1:0]       preload_ff, preload_in;
   logic [bac_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            bit_ff, bit_in;
   logic [bac_pkg::PRED_W-1:0]      pred_ff, pred_in;
   logic [bac_pkg::PROD_W-1:0]      product_ff, product_in;
   logic                            dec_bit_ff, dec_bit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_bit_ff, rsp_bit_in;
   logic [bac_pkg::CNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [W-1:0] span;
   logic [W-1:0] split_raw;
   logic [W-1:0] split_hi;
   logic [W-1:0] split_pt;
   logic         chosen_bit;

   // Split point: low plus truncated share of the span, kept strictly inside
   always_comb begin
      span      = high_ff - low_ff;
      split_raw = product_ff[bac_pkg::PROD_W-1:bac_pkg::PRED_W] + low_ff;
      split_hi  = (high_ff <= split_raw) ? (high_ff - W'(1)) : split_raw;
      split_pt  = (low_ff >= split_hi) ? (low_ff + W'(1)) : split_hi;
      chosen_bit = cmd.split_decode ? (window_ff > split_pt) : bit_ff;
   end

   // Next values of the coder state
   always_comb begin
      low_in     = low_ff;
      high_in    = high_ff;
      window_in  = window_ff;
      preload_in = preload_ff;
      count_in   = count_ff;
      bit_in     = bit_ff;
      pred_in    = pred_ff;
      product_in = product_ff;
      dec_bit_in = dec_bit_ff;

      if (cmd.latch) begin
         bit_in   = req_bit;
         pred_in  = req_pred;
         count_in = '0;
      end
      if (cmd.code_in) begin
         window_in = {window_ff[W-2:0], req_bit};
         if (preload_ff != '0) begin
            preload_in = preload_ff - bac_pkg::CNT_W'(1);
         end
      end
      if (cmd.mul) begin
         product_in = bac_pkg::PROD_W'(span) * bac_pkg::PROD_W'(pred_ff);
      end
      if (cmd.split) begin
         dec_bit_in = chosen_bit;
         if (chosen_bit) begin
            low_in = split_pt + W'(1);
         end else begin
            high_in = split_pt;
         end
      end
      if (cmd.shift) begin
         low_in   = {low_ff[W-2:0], 1'b0};
         high_in  = {high_ff[W-2:0], 1'b1};
         count_in = count_ff + bac_pkg::CNT_W'(1);
      end
   end

   // Response register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.emit_last;
         unique case (cmd.emit_kind)
            bac_pkg::EMIT_CODE: begin
               rsp_bit_in   = high_ff[W-1];
               rsp_count_in = '0;
            end
            bac_pkg::EMIT_DECODE: begin
               rsp_bit_in   = dec_bit_ff;
               rsp_count_in = count_ff;
            end
            bac_pkg::EMIT_PRELOAD: begin
               rsp_bit_in   = 1'b0;
               rsp_count_in = preload_ff;
            end
            default: begin
               rsp_bit_in   = 1'b0;
               rsp_count_in = '0;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= '1;
         window_ff    <= '0;
         preload_ff   <= bac_pkg::CNT_W'(W);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         window_ff    <= window_in;
         preload_ff   <= preload_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff       <= bit_in;
      pred_ff      <= pred_in;
      product_ff   <= product_in;
      dec_bit_ff   <= dec_bit_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Status back to the controller
   always_comb begin
      status.agree        = (low_ff[W-1] == high_ff[W-1]);
      status.agree_next   = (low_ff[W-2] == high_ff[W-2]);
      status.count_last   = (count_ff == bac_pkg::CNT_W'(W - 1));
      status.count_full   = (count_ff == bac_pkg::CNT_W'(W));
      status.preload_zero = (preload_ff == '0);
      status.out_free     = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_out_bit = rsp_bit_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

FILE: hdl/bac_controller.sv
module bac_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bac_pkg::mode_type    req_mode,
   input  bac_pkg::status_type  status,
   output bac_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENC_MUL,
      ST_ENC_SPLIT,
      ST_ENC_SHIFT,
      ST_FLUSH,
      ST_DEC_PRE,
      ST_DEC_MUL,
      ST_DEC_SPLIT,
      ST_DEC_SHIFT
   } state_type;

   state_type state_ff, state_in;
   logic      enc_last;

   assign enc_last = status.count_last || !status.agree_next;

   // Sequence one item at a time
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.emit_kind    = bac_pkg::EMIT_CODE;
      req_tready       = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               unique case (req_mode)
                  bac_pkg::MODE_ENCODE:  state_in = ST_ENC_MUL;
                  bac_pkg::MODE_FLUSH:   state_in = ST_FLUSH;
                  bac_pkg::MODE_DECODE:
                     state_in = status.preload_zero ? ST_DEC_MUL : ST_DEC_PRE;
                  bac_pkg::MODE_CODE_IN: cmd.code_in = 1'b1;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_ENC_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ENC_SPLIT;
         end
         ST_ENC_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_ENC_SHIFT;
         end
         ST_ENC_SHIFT: begin
            // emit one code bit per shared top bit
            if (!status.agree) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = enc_last;
               cmd.shift     = 1'b1;
               if (enc_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = status.count_last;
               cmd.shift     = 1'b1;
               if (status.count_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DEC_PRE: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = bac_pkg::EMIT_PRELOAD;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DEC_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DEC_SPLIT;
         end
         ST_DEC_SPLIT: begin
            cmd.split        = 1'b1;
            cmd.split_decode = 1'b1;
            state_in         = ST_DEC_SHIFT;
         end
         ST_DEC_SHIFT: begin
            // count shifts, then answer once
            if (status.agree && !status.count_full) begin
               cmd.shift = 1'b1;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = bac_pkg::EMIT_DECODE;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/binary_arithmetic_coder.sv
// Carryless 32-bit binary arithmetic coder, encoder and decoder in one block.
// Each request beat carries a mode on req_tuser and a bit plus a 16-bit
// probability of zero on req_tdata. A coded-bit-in beat gives no response. An
// encode beat emits one code bit per response beat (0 to 32 response beats,
// the final one marked by rsp_tlast). A decode beat answers with one beat
// holding the decoded bit and the number of code bits to send next, which is
// the number of bound shifts it counts; before the 32-bit code window is
// preloaded it answers with the bits still missing. A flush beat emits 32
// code bits. The work is done by the registered 32x16 split multiply, the
// registered split clamp, and the single-place bound shifter; a stalled
// rsp_tready holds the shifter while encoding or flushing.
module binary_arithmetic_coder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [0] data_bit, [16:1] prediction, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] out_bit, [6:1] shifts_needed, rest zero
   output logic        rsp_tlast
);

   bac_pkg::cmd_type               cmd;
   bac_pkg::status_type            status;
   bac_pkg::mode_type              req_mode;
   logic                           rsp_out_bit;
   logic [bac_pkg::CNT_W-1:0]      rsp_count;

   assign req_mode  = bac_pkg::mode_type'(req_tuser);
   assign rsp_tdata = {1'b0, rsp_count, rsp_out_bit};

   bac_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_mode),
      .status     (status),
      .cmd        (cmd)
   );

   bac_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_bit     (req_tdata[0]),
      .req_pred    (req_tdata[16:1]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_out_bit (rsp_out_bit),
      .rsp_count   (rsp_count),
      .rsp_last    (rsp_tlast)
   );

endmodule
